@@ src/assert_macros.svh @@
// Assertion macros used by the checker file of the video RAM port.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock edge, off while reset is held.
`define VRP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Concurrent assertion on the rising clock edge that also holds during reset.
`define VRP_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/vrp_pkg.sv @@
// Shared types and constants of the video RAM register port.
`timescale 1ns / 1ps
`default_nettype none

package vrp_pkg;

	// Request actions.
	typedef enum logic [1:0] {
		ACT_ADDR  = 2'd0,
		ACT_READ  = 2'd1,
		ACT_WRITE = 2'd2,
		ACT_LOAD  = 2'd3
	} vrp_action_t;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_RD1  = 2'd1,
		ST_RD2  = 2'd2,
		ST_WR2  = 2'd3
	} vrp_state_t;

	// Register index of the pointer step mode.
	localparam logic REG_INC = 1'b0;

	localparam int unsigned ADDR_W = 14;

	// Address map constants.
	localparam logic [ADDR_W-1:0] NT_BASE    = 14'h2000;
	localparam logic [ADDR_W-1:0] NT_END     = 14'h3000;
	localparam logic [ADDR_W-1:0] PAL_BASE   = 14'h3F00;
	localparam logic [ADDR_W-1:0] PAL_HI     = 14'h3F10;
	localparam logic [ADDR_W-1:0] PAIR_OFS   = 14'h0400;
	localparam logic [ADDR_W-1:0] PAL_SHADOW = 14'h1000;

	// One request transaction.
	typedef struct packed {
		vrp_action_t             action;
		logic [7:0]              value;
		logic [ADDR_W-1:0]       address;
	} vrp_req_t;

	// One response transaction.
	typedef struct packed {
		logic [7:0] read_data;
		logic       is_read;
	} vrp_rsp_t;

	// Memory writes caused by one request.
	typedef struct packed {
		logic              en;
		logic              second;
		logic [ADDR_W-1:0] addr0;
		logic [ADDR_W-1:0] addr1;
	} vrp_wr_plan_t;

endpackage

`default_nettype wire

@@ src/video_ram_register_port.sv @@
// Video RAM register port: pointer latch, buffered data port, mirrored writes.
// Address byte writes, pattern loads and data writes, mirrored ones too, answer in the
// cycle after acceptance; buffered reads answer after ST_RD1, palette reads after ST_RD2.
// A new request is taken only in ST_IDLE with the response slot free; a mirrored write
// holds ST_WR2, a read ST_RD1 and a palette read also ST_RD2, as the memory has one port.
// Reset clears pointer, byte latch, read buffer and step mode; memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module video_ram_register_port (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire vrp_pkg::vrp_req_t req,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output vrp_pkg::vrp_rsp_t      rsp,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [2:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);
	import vrp_pkg::*;

	vrp_state_t        state_q, state_d;
	logic [15:0]       ptr_q;
	logic              lo_next_q;
	logic [7:0]        buf_q;
	logic              inc_q;
	logic [ADDR_W-1:0] rd_addr_q;
	logic [ADDR_W-1:0] wr_addr_q;
	logic [7:0]        wr_data_q;
	logic              rsp_valid_q;
	vrp_rsp_t          rsp_q;

	logic              accept;
	logic              pal_read;
	logic [ADDR_W-1:0] step;
	vrp_wr_plan_t      plan;

	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [7:0]        mem_wdata;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_raddr;
	logic [7:0]        mem_rdata;

	// Configuration port.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_INC) ? {31'd0, inc_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inc_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_INC) begin
			inc_q <= pwdata[0];
		end
	end

	// Handshake.
	assign req_ready = (state_q == ST_IDLE) && (!rsp_valid_q || rsp_ready);
	assign accept    = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign pal_read = (rd_addr_q >= PAL_BASE);
	assign step     = inc_q ? ADDR_W'(32) : ADDR_W'(1);

	vrp_wr_map u_wr_map (
		.action  (req.action),
		.address (req.address),
		.plan    (plan)
	);

	vrp_mem u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req.action == ACT_READ) begin
						state_d = ST_RD1;
					end else if (plan.en && plan.second) begin
						state_d = ST_WR2;
					end
				end
			end
			ST_RD1:  state_d = pal_read ? ST_RD2 : ST_IDLE;
			ST_RD2:  state_d = ST_IDLE;
			ST_WR2:  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Memory port control per state.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = wr_addr_q;
		mem_wdata = wr_data_q;
		mem_re    = 1'b0;
		mem_raddr = ptr_q[ADDR_W-1:0];
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					mem_re    = (req.action == ACT_READ);
					mem_we    = plan.en;
					mem_waddr = plan.addr0;
					mem_wdata = req.value;
				end
			end
			ST_RD1: begin
				mem_re    = pal_read;
				mem_raddr = rd_addr_q - PAL_SHADOW;
			end
			ST_WR2: begin
				mem_we = 1'b1;
			end
			ST_RD2: begin
				mem_re = 1'b0;
			end
			default: begin
				mem_re = 1'b0;
			end
		endcase
	end

	// Control state: FSM, pointer, byte latch, buffer and response valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ptr_q       <= '0;
			lo_next_q   <= 1'b0;
			buf_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// A new response wins over the hand-off of the previous one.
			if ((accept && req.action != ACT_READ) || (state_q == ST_RD1 && !pal_read)
					|| (state_q == ST_RD2)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (accept) begin
				if (req.action == ACT_ADDR) begin
					if (lo_next_q) begin
						ptr_q[7:0] <= req.value;
					end else begin
						ptr_q[15:8] <= req.value;
					end
					lo_next_q <= !lo_next_q;
				end else if (req.action == ACT_READ) begin
					ptr_q <= {2'b00, ptr_q[ADDR_W-1:0] + step};
				end
			end
			if (state_q == ST_RD1 && !pal_read) begin
				buf_q <= mem_rdata;
			end
			if (state_q == ST_RD2) begin
				buf_q <= mem_rdata;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_addr_q <= ptr_q[ADDR_W-1:0];
			wr_addr_q <= plan.addr1;
			wr_data_q <= req.value;
			if (req.action != ACT_READ) begin
				rsp_q <= '0;
			end
		end
		if (state_q == ST_RD1) begin
			rsp_q.is_read   <= 1'b1;
			rsp_q.read_data <= pal_read ? mem_rdata : buf_q;
		end
	end

endmodule

`default_nettype wire

@@ src/vrp_mem.sv @@
// 16 KiB video memory with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module vrp_mem (
	input  wire logic                      clk,
	input  wire logic                      we,
	input  wire logic [vrp_pkg::ADDR_W-1:0] waddr,
	input  wire logic [7:0]                wdata,
	input  wire logic                      re,
	input  wire logic [vrp_pkg::ADDR_W-1:0] raddr,
	output logic      [7:0]                rdata
);
	import vrp_pkg::*;

	logic [7:0] mem [0:(1 << ADDR_W) - 1];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, registered: data valid in the cycle after the request.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ src/vrp_wr_map.sv @@
// Address mapping of data writes and pattern loads onto memory writes.
`timescale 1ns / 1ps
`default_nettype none

module vrp_wr_map (
	input  wire vrp_pkg::vrp_action_t       action,
	input  wire logic [vrp_pkg::ADDR_W-1:0] address,
	output vrp_pkg::vrp_wr_plan_t           plan
);
	import vrp_pkg::*;

	logic [ADDR_W-1:0] grp;
	logic [ADDR_W-1:0] idx;

	assign grp = {{(ADDR_W-4){1'b0}}, address[3:2], 2'b00};
	assign idx = {{(ADDR_W-5){1'b0}}, address[4:0]};

	// Name tables under NT_END mirror to a pair; palette folds to 32.
	always_comb begin
		plan = '0;
		unique case (action)
			ACT_WRITE: begin
				if (address >= PAL_BASE) begin
					plan.en = 1'b1;
					if (address[1:0] == 2'b00) begin
						plan.second = 1'b1;
						plan.addr0  = PAL_BASE | grp;
						plan.addr1  = PAL_HI | grp;
					end else begin
						plan.addr0 = PAL_BASE | idx;
					end
				end else if (address >= NT_BASE) begin
					plan.en     = 1'b1;
					plan.addr0  = address;
					plan.second = (address < NT_END);
					plan.addr1  = address ^ PAIR_OFS;
				end
			end
			ACT_LOAD: begin
				plan.en    = (address < NT_BASE);
				plan.addr0 = address;
			end
			ACT_ADDR, ACT_READ: begin
				plan = '0;
			end
			default: begin
				plan = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ src/vrp_checker.sv @@
// Port-level checker of the video RAM register port and its bind statement.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module vrp_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              req_valid,
	input wire logic              req_ready,
	input wire vrp_pkg::vrp_req_t req,
	input wire logic              rsp_valid,
	input wire logic              rsp_ready,
	input wire vrp_pkg::vrp_rsp_t rsp
);
	import vrp_pkg::*;

	// A stalled response transaction keeps its payload.
	`VRP_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp),
		"response changed while stalled")

	// Only reads return data.
	`VRP_ASSERT(a_nonread_zero, rsp_valid && !rsp.is_read |-> rsp.read_data == 8'd0,
		"non-read response carries data")

	// Non-read requests are answered in the next cycle.
	`VRP_ASSERT(a_nonread_next,
		req_valid && req_ready && req.action != ACT_READ |=> rsp_valid && !rsp.is_read,
		"non-read response missing")

	// A read needs the memory, so nothing is answered in the next cycle.
	`VRP_ASSERT(a_read_wait, req_valid && req_ready && req.action == ACT_READ |=> !rsp_valid,
		"read answered too early")

	// No response is offered once reset has been seen.
	`VRP_ASSERT_RST(a_rst_quiet, !arst_n |=> !rsp_valid, "response valid during reset")

endmodule

bind video_ram_register_port vrp_checker u_vrp_checker (.*);

`default_nettype wire
